FILE: rtl/ahps_pkg.sv
// Package for the axis home-and-position sequencer.
// Request/result structs, phase and error codes, fixed-point constants.
// No dependencies.
package ahps_pkg;

    localparam int CMD_W   = 2;
    localparam int POS_W   = 40;
    localparam int TGT_W   = 24;
    localparam int CNT_W   = 32;
    localparam int STEPS_W = 32;
    localparam int CF_W    = 16;
    localparam int HL_W    = 24;
    localparam int TOL_W   = 10;
    localparam int ATT_W   = 5;

    localparam logic [CMD_W-1:0] CMD_MOVE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_HOME   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_BLOCK = 2'd1;
    localparam logic [1:0] KIND_ASYNC = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NOT_HOMED = 3'd1;
    localparam logic [2:0] ERR_ATTEMPTS  = 3'd2;
    localparam logic [2:0] ERR_LEAVE     = 3'd3;
    localparam logic [2:0] ERR_FIND_LIM  = 3'd4;
    localparam logic [2:0] ERR_FIND_IDX  = 3'd5;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_MOVE  = 3'd1;
    localparam logic [2:0] PH_LEAVE = 3'd2;
    localparam logic [2:0] PH_SEEK  = 3'd3;
    localparam logic [2:0] PH_INDEX = 3'd4;

    localparam logic [1:0] REG_DIR = 2'd0;
    localparam logic [1:0] REG_CF  = 2'd1;
    localparam logic [1:0] REG_HL  = 2'd2;

    localparam logic [TOL_W-1:0] TOL_FINE   = 10'd256;
    localparam logic [TOL_W-1:0] TOL_COARSE = 10'd512;
    localparam logic [TOL_W-1:0] TOL_TIGHT  = 10'd128;
    localparam logic [TOL_W-1:0] TOL_WIDE   = 10'd192;
    localparam logic [ATT_W-1:0] ATT_MAX    = 5'd20;
    localparam logic [ATT_W-1:0] ATT_WIDE   = 5'd15;
    localparam logic [ATT_W-1:0] ATT_TIGHT  = 5'd10;

    localparam logic [29:0] POS_NUM  = 30'd866983936;
    localparam logic [16:0] POS_DEN  = 17'd78125;
    localparam logic [11:0] STEP_NUM = 12'd3125;
    localparam logic [27:0] STEP_DEN = 28'd216745984;
    // STEP_DEN = 2^11 * odd part; the odd part is divided by reciprocal multiply
    localparam logic [16:0] STEP_DIV   = 17'(STEP_DEN >> 11);
    localparam logic [25:0] STEP_RECIP = 26'((64'd1 << 42) / 64'(STEP_DIV));
    localparam logic signed [STEPS_W-1:0] BACKLASH = 32'sd400;
    localparam logic signed [STEPS_W-1:0] MIN_STEPS = 32'sd16;
    localparam logic signed [STEPS_W-1:0] INDEX_STEPS = 32'sd3840;
    localparam logic signed [POS_W-1:0] UNHOMED_POS = 40'sd3160320;

    localparam logic [1:0] DEF_DIR = 2'd0;
    localparam logic [CF_W-1:0] DEF_CF = 16'd4096;
    localparam logic [HL_W-1:0] DEF_HL = 24'd65536;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [23:0] target_pos;
        logic               coarse;
        logic signed [31:0] encoder_count;
        logic               limit_level;
        logic               index_level;
        logic               speed_low;
        logic               move_done;
    } req_t;

    typedef struct packed {
        logic               motor_enable;
        logic [1:0]         move_kind;
        logic signed [31:0] move_steps;
        logic               stop_motion;
        logic               zero_position;
        logic               finished;
        logic               success;
        logic [2:0]         error_code;
        logic               homed_flag;
        logic signed [39:0] position;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic pos_start;    // convert encoder count to position
        logic steps_start;  // convert target - position to steps
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pos_done;
        logic steps_done;
        logic out_tol;
    } dp_sts_t;

endpackage

FILE: rtl/ahps_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; widths set by parameters.
module ahps_divider #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[NUM_W-1]} - {1'b0, den_reg};
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            cnt_next  = CW'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W])
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DEN_W-2:0], quo_reg[NUM_W-1]};
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            den_reg <= den;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

FILE: rtl/ahps_datapath.sv
// Datapath: encoder-to-position and error-to-steps conversion.
// Uses ahps_pkg and ahps_divider (position divide); steps use a reciprocal multiply.
module ahps_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ahps_pkg::dp_cmd_t            cmd,
    output ahps_pkg::dp_sts_t            sts,
    input  logic                         dir_inv,
    input  logic [ahps_pkg::CF_W-1:0]    cf,
    input  logic signed [31:0]           count,
    input  logic signed [23:0]           target,
    input  logic [ahps_pkg::TOL_W-1:0]   tol,
    output logic signed [39:0]           pos,
    output logic signed [31:0]           steps
);
    import ahps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PM, S_PD, S_PW, S_PS,
        S_SM, S_RH, S_RL, S_RQ, S_RP, S_RC, S_SM2, S_SS
    } dstate_t;

    dstate_t st_reg;
    logic [CF_W-1:0] cfe;
    logic [39:0] mag_reg;
    logic        neg_reg;
    logic [63:0] prod_reg;
    logic [51:0] dx_reg;      // dividend of the divide by STEP_DEN
    logic [66:0] macc_reg;    // (dx >> 11) * STEP_RECIP
    logic [24:0] qe_reg;      // quotient estimate, low by at most one
    logic [17:0] ry_reg;      // (dx >> 11) - qe * STEP_DIV, below 2 * STEP_DIV
    logic [17:0] ry_sub;
    logic [41:0] qd_prod;
    logic [24:0] q_reg;
    logic [27:0] r_reg;
    logic        pass_reg;    // 0: mag * 3125 / STEP_DEN, 1: rem * cf / STEP_DEN
    logic [40:0] acc_reg;
    logic signed [39:0] pos_reg;
    logic signed [31:0] steps_reg;
    logic        div_start;
    logic [63:0] div_num;
    logic [47:0] div_den;
    logic        div_done;
    logic [63:0] div_quo;
    logic        pos_done_reg, steps_done_reg;
    logic signed [32:0] cnt_v;
    logic signed [41:0] diff;
    logic [41:0] dmag;
    logic [63:0] s_sum;
    logic signed [32:0] st_sat;
    logic signed [33:0] st_bl;
    logic signed [40:0] ddiff;
    logic [40:0] absd;

    assign cfe   = (cf == '0) ? CF_W'(1) : cf;
    assign cnt_v = dir_inv ? 33'(count) : -33'(count);
    assign diff  = 42'(target) - 42'(pos_reg);
    assign dmag  = diff[41] ? 42'(-diff) : diff;
    assign s_sum = 64'(acc_reg) + 64'(q_reg);
    assign ddiff = 41'(target) - 41'(pos_reg);
    assign absd  = ddiff[40] ? 41'(-ddiff) : ddiff;
    assign ry_sub  = ry_reg - 18'(STEP_DIV);
    assign qd_prod = 42'(qe_reg) * 42'(STEP_DIV);
    assign sts.out_tol    = absd > 41'(tol);
    assign sts.pos_done   = pos_done_reg;
    assign sts.steps_done = steps_done_reg;
    assign pos   = pos_reg;
    assign steps = steps_reg;

    assign div_start = (st_reg == S_PD);
    assign div_num   = prod_reg;
    assign div_den   = 48'(POS_DEN) * 48'(cfe);

    // saturate magnitude with sign, then backlash
    always_comb
    begin
        if (neg_reg)
            st_sat = (s_sum > 64'd2147483648) ? -33'sd2147483648 : -33'(s_sum[32:0]);
        else
            st_sat = (s_sum > 64'd2147483647) ? 33'sd2147483647 : 33'(s_sum[32:0]);
        st_bl = 34'(st_sat);
        if (st_sat < 33'(MIN_STEPS))
            st_bl = 34'(st_sat) - 34'(BACKLASH);
        if (st_bl < -34'sd2147483648)
            st_bl = -34'sd2147483648;
    end

    ahps_divider #(.NUM_W(64), .DEN_W(48)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quo(div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= S_IDLE;
            pos_done_reg   <= 1'b0;
            steps_done_reg <= 1'b0;
        end
        else
        begin
            pos_done_reg   <= 1'b0;
            steps_done_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (cmd.pos_start) st_reg <= S_PM;
                    else if (cmd.steps_start) st_reg <= S_SM;
                end
                S_PM:  st_reg <= S_PD;
                S_PD:  st_reg <= S_PW;
                S_PW:  if (div_done) st_reg <= S_PS;
                S_PS:  begin st_reg <= S_IDLE; pos_done_reg <= 1'b1; end
                S_SM:  st_reg <= S_RH;
                S_RH:  st_reg <= S_RL;
                S_RL:  st_reg <= S_RQ;
                S_RQ:  st_reg <= S_RP;
                S_RP:  st_reg <= S_RC;
                S_RC:  st_reg <= pass_reg ? S_SS : S_SM2;
                S_SM2: st_reg <= S_RH;
                S_SS:  begin st_reg <= S_IDLE; steps_done_reg <= 1'b1; end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            S_IDLE:
            begin
                if (cmd.pos_start)
                begin
                    neg_reg <= cnt_v[32];
                    mag_reg <= 40'(cnt_v[32] ? 32'(-cnt_v) : cnt_v[31:0]);
                end
                else
                begin
                    neg_reg <= diff[41];
                    mag_reg <= dmag[39:0];
                end
            end
            S_PM:  prod_reg <= 64'(mag_reg[31:0]) * 64'(POS_NUM);
            S_PS:
            begin
                if (neg_reg)
                    pos_reg <= (div_quo > 64'h80_0000_0000) ? -40'sh80_0000_0000
                                                            : -40'(div_quo[39:0]);
                else
                    pos_reg <= (div_quo > 64'h7F_FFFF_FFFF) ? 40'sh7F_FFFF_FFFF
                                                            : 40'(div_quo[39:0]);
            end
            S_SM:
            begin
                dx_reg   <= 52'(mag_reg) * 52'(STEP_NUM);
                pass_reg <= 1'b0;
            end
            // dx / STEP_DEN: split the reciprocal product into two halves
            S_RH:  macc_reg <= {46'(dx_reg[51:32]) * 46'(STEP_RECIP), 21'd0};
            S_RL:  macc_reg <= macc_reg + 67'(47'(dx_reg[31:11]) * 47'(STEP_RECIP));
            S_RQ:  qe_reg <= macc_reg[66:42];
            S_RP:  ry_reg <= dx_reg[28:11] - qd_prod[17:0];
            S_RC:
            begin
                if (ry_reg >= 18'(STEP_DIV))
                begin
                    q_reg <= qe_reg + 25'd1;
                    r_reg <= {ry_sub[16:0], dx_reg[10:0]};
                end
                else
                begin
                    q_reg <= qe_reg;
                    r_reg <= {ry_reg[16:0], dx_reg[10:0]};
                end
            end
            S_SM2:
            begin
                acc_reg  <= 41'(q_reg) * 41'(cfe);
                dx_reg   <= 52'(r_reg) * 52'(cfe);
                pass_reg <= 1'b1;
            end
            S_SS:  steps_reg <= st_bl[31:0];
            default: ;
        endcase
    end
endmodule

FILE: rtl/ahps_controller.sv
// Sequencer state machine: move attempts, homing phases, result assembly.
// Uses ahps_pkg; drives the datapath through dp_cmd_t / dp_sts_t.
module ahps_controller (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  ahps_pkg::req_t             in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ahps_pkg::rsp_t             out_data,
    input  logic [ahps_pkg::HL_W-1:0]  hl,
    output ahps_pkg::dp_cmd_t          dcmd,
    input  ahps_pkg::dp_sts_t          dsts,
    output logic signed [23:0]         target,
    output logic [ahps_pkg::TOL_W-1:0] tol,
    output logic signed [31:0]         count,
    input  logic signed [39:0]         pos,
    input  logic signed [31:0]         steps
);
    import ahps_pkg::*;

    typedef enum logic [2:0] {C_IDLE, C_POS, C_DEC, C_STEPS, C_OUT} cstate_t;

    cstate_t st_reg;
    req_t    req_reg;
    rsp_t    rsp_reg;
    logic [2:0] phase_reg;
    logic       homed_reg;
    logic [ATT_W-1:0] att_reg;
    logic [TOL_W-1:0] tol_reg;
    logic signed [23:0] tgt_reg;
    logic       en_reg;
    logic [2:0] ph_n;
    logic       homed_n, en_n, need_steps;
    logic [ATT_W-1:0] att_n;
    logic [TOL_W-1:0] tol_n;
    logic signed [23:0] tgt_n;
    rsp_t r;
    logic signed [31:0] hls;

    assign hls      = 32'(signed'({1'b0, hl}));
    assign in_ready = (st_reg == C_IDLE);
    assign out_valid = (st_reg == C_OUT);
    assign out_data = rsp_reg;
    assign target   = tgt_reg;
    assign tol      = tol_reg;
    // sampled by the datapath only in the accept cycle, straight from the request
    assign count    = in_data.encoder_count;
    assign dcmd.pos_start   = (st_reg == C_IDLE) && in_valid;
    assign dcmd.steps_start = (st_reg == C_DEC) && need_steps;

    // decision on request + converted position (target/tol already updated
    // for the out-of-tolerance check is done in a later cycle, see C_DEC)
    always_comb
    begin
        ph_n = phase_reg; homed_n = homed_reg; att_n = att_reg; tol_n = tol_reg;
        tgt_n = tgt_reg; en_n = en_reg;
        r = '0;
        if (phase_reg == PH_IDLE && req_reg.cmd == CMD_MOVE)
        begin
            if (!homed_reg)
            begin
                r.finished = 1'b1; r.error_code = ERR_NOT_HOMED;
            end
            else
            begin
                en_n = 1'b1; tgt_n = req_reg.target_pos; att_n = '0;
                tol_n = req_reg.coarse ? TOL_COARSE : TOL_FINE;
            end
        end
        else if (phase_reg == PH_IDLE && req_reg.cmd == CMD_HOME)
        begin
            en_n = 1'b1; r.move_kind = KIND_ASYNC;
            if (req_reg.limit_level)
            begin
                r.move_steps = hls; ph_n = PH_LEAVE;
            end
            else
            begin
                r.move_steps = -hls; ph_n = PH_SEEK;
            end
        end
        else if (req_reg.cmd == CMD_SAMPLE)
        begin
            if (phase_reg == PH_MOVE && req_reg.move_done)
            begin
                if (att_reg >= ATT_MAX)
                begin
                    r.finished = 1'b1; r.error_code = ERR_ATTEMPTS; ph_n = PH_IDLE;
                end
                else
                begin
                    if (att_reg == ATT_WIDE) tol_n = TOL_WIDE;
                    else if (att_reg == ATT_TIGHT) tol_n = TOL_TIGHT;
                    att_n = att_reg + 1'b1;
                end
            end
            else if (phase_reg == PH_LEAVE)
            begin
                if (!req_reg.limit_level)
                begin
                    r.stop_motion = 1'b1; r.move_kind = KIND_ASYNC;
                    r.move_steps = -hls; ph_n = PH_SEEK;
                end
                else if (req_reg.speed_low)
                begin
                    r.stop_motion = 1'b1; r.finished = 1'b1; r.error_code = ERR_LEAVE;
                    en_n = 1'b0; ph_n = PH_IDLE;
                end
            end
            else if (phase_reg == PH_SEEK)
            begin
                if (req_reg.limit_level)
                begin
                    r.stop_motion = 1'b1; r.move_kind = KIND_ASYNC;
                    r.move_steps = INDEX_STEPS; ph_n = PH_INDEX;
                end
                else if (req_reg.speed_low)
                begin
                    r.stop_motion = 1'b1; r.finished = 1'b1; r.error_code = ERR_FIND_LIM;
                    en_n = 1'b0; ph_n = PH_IDLE;
                end
            end
            else if (phase_reg == PH_INDEX)
            begin
                if (req_reg.index_level)
                begin
                    r.stop_motion = 1'b1; r.zero_position = 1'b1; r.finished = 1'b1;
                    r.success = 1'b1; homed_n = 1'b1; en_n = 1'b0; ph_n = PH_IDLE;
                end
                else if (req_reg.speed_low)
                begin
                    r.stop_motion = 1'b1; r.finished = 1'b1; r.error_code = ERR_FIND_IDX;
                    en_n = 1'b0; ph_n = PH_IDLE;
                end
            end
            else if (phase_reg > PH_INDEX)
                ph_n = PH_IDLE;
        end
        r.homed_flag = homed_n;
        r.motor_enable = en_n;
        if (r.zero_position) r.position = '0;
        else if (homed_n) r.position = pos;
        else r.position = UNHOMED_POS;
    end

    // C_DEC runs after target/tol are committed: tolerance check phase
    logic chk;
    assign chk = (phase_reg == PH_IDLE && req_reg.cmd == CMD_MOVE && homed_reg) ||
                 (phase_reg == PH_MOVE && req_reg.cmd == CMD_SAMPLE &&
                  req_reg.move_done && att_reg >= 5'd1 && rsp_reg.move_kind == KIND_NONE
                  && !rsp_reg.finished);

    always_comb need_steps = chk && dsts.out_tol;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= C_IDLE; phase_reg <= PH_IDLE; homed_reg <= 1'b0;
            att_reg <= '0; tol_reg <= TOL_FINE; tgt_reg <= '0; en_reg <= 1'b0;
        end
        else
        begin
            unique case (st_reg)
                C_IDLE: if (in_valid) st_reg <= C_POS;
                C_POS:
                begin
                    if (dsts.pos_done)
                    begin
                        rsp_reg <= r;
                        phase_reg <= ph_n; homed_reg <= homed_n; att_reg <= att_n;
                        tol_reg <= tol_n; tgt_reg <= tgt_n; en_reg <= en_n;
                        st_reg <= C_DEC;
                    end
                end
                C_DEC:
                begin
                    if (chk)
                    begin
                        if (dsts.out_tol)
                        begin
                            phase_reg <= PH_MOVE; st_reg <= C_STEPS;
                            rsp_reg.move_kind <= KIND_BLOCK;
                        end
                        else
                        begin
                            en_reg <= 1'b0; phase_reg <= PH_IDLE; st_reg <= C_OUT;
                            rsp_reg.motor_enable <= 1'b0; rsp_reg.finished <= 1'b1;
                            rsp_reg.success <= 1'b1;
                        end
                    end
                    else
                        st_reg <= C_OUT;
                end
                C_STEPS:
                begin
                    if (dsts.steps_done)
                    begin
                        rsp_reg.move_steps <= steps; st_reg <= C_OUT;
                    end
                end
                C_OUT: if (out_ready) st_reg <= C_IDLE;
                default: st_reg <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == C_IDLE && in_valid)
            req_reg <= in_data;
    end
endmodule

FILE: rtl/axis_home_and_position_sequencer.sv
// Top level of the axis home-and-position sequencer.
// Uses ahps_pkg, ahps_controller, ahps_datapath (and ahps_divider below it).
//
// One request in, one result out. Every request first converts the encoder
// count to a position through a 64-bit restoring divider. A move that needs
// steps adds a divide by a fixed constant done twice by reciprocal multiply,
// plus setup and wrap-up. Requests are taken one at a time; the result waits
// in an output register until taken.
// Configuration is an APB-style port:
// 0x0 direction_inverted, 0x4 correction_factor_q12, 0x8 homing_step_limit.
module axis_home_and_position_sequencer #(
    parameter logic [ahps_pkg::CF_W-1:0] CF_RESET = ahps_pkg::DEF_CF,
    parameter logic [ahps_pkg::HL_W-1:0] HL_RESET = ahps_pkg::DEF_HL
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ahps_pkg::req_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ahps_pkg::rsp_t  out_data,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);
    import ahps_pkg::*;

    logic            dir_reg;
    logic [CF_W-1:0] cf_reg;
    logic [HL_W-1:0] hl_reg;
    dp_cmd_t         dcmd;
    dp_sts_t         dsts;
    logic signed [23:0] target;
    logic [TOL_W-1:0]   tol;
    logic signed [31:0] count;
    logic signed [39:0] pos;
    logic signed [31:0] steps;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= DEF_DIR[0];
            cf_reg  <= CF_RESET;
            hl_reg  <= HL_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_DIR: dir_reg <= pwdata[0];
                REG_CF:  cf_reg  <= pwdata[CF_W-1:0];
                REG_HL:  hl_reg  <= pwdata[HL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DIR: prdata = {31'd0, dir_reg};
            REG_CF:  prdata = 32'(cf_reg);
            REG_HL:  prdata = 32'(hl_reg);
            default: prdata = '0;
        endcase
    end

    ahps_controller u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
        .out_data(out_data), .hl(hl_reg), .dcmd(dcmd), .dsts(dsts),
        .target(target), .tol(tol), .count(count), .pos(pos), .steps(steps)
    );

    ahps_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(dcmd), .sts(dsts), .dir_inv(dir_reg),
        .cf(cf_reg), .count(count), .target(target), .tol(tol),
        .pos(pos), .steps(steps)
    );
endmodule
